/* src/ecbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ecbd_pkg: shared types and codes of the expansion card bus decoder
// transfer payloads, access opcodes, store targets, flash requests, io ports
// ----------------------------------------------------------------------------
package ecbd_pkg;

  localparam int EXPANDED_BYTES_DEF = 327680;
  localparam int FONT_BYTES_DEF     = 4096;

  localparam int ADDR_W      = 19;
  localparam int ROM_PTR_W   = 16;
  localparam int BOOT_PTR_W  = 15;
  localparam int FONT_PTR_W  = 12;

  // access opcodes
  localparam logic [1:0] OP_IO_READ   = 2'd0;
  localparam logic [1:0] OP_IO_WRITE  = 2'd1;
  localparam logic [1:0] OP_MEM_WRITE = 2'd2;

  // store targets
  localparam logic [3:0] TGT_NONE     = 4'd0;
  localparam logic [3:0] TGT_KANJI    = 4'd1;
  localparam logic [3:0] TGT_DICT     = 4'd2;
  localparam logic [3:0] TGT_BOOT     = 4'd3;
  localparam logic [3:0] TGT_EXPANDED = 4'd4;
  localparam logic [3:0] TGT_FONT     = 4'd5;
  localparam logic [3:0] TGT_TEXT     = 4'd6;
  localparam logic [3:0] TGT_PLANE1   = 4'd7;
  localparam logic [3:0] TGT_PLANE2   = 4'd8;

  // flash requests
  localparam logic [2:0] FL_NONE          = 3'd0;
  localparam logic [2:0] FL_BOOT_LOAD     = 3'd1;
  localparam logic [2:0] FL_BOOT_SAVE     = 3'd2;
  localparam logic [2:0] FL_EXPANDED_LOAD = 3'd3;
  localparam logic [2:0] FL_EXPANDED_SAVE = 3'd4;

  // io ports (low byte of the bus address)
  localparam logic [7:0] PORT_ROM_LO      = 8'hB8;
  localparam logic [7:0] PORT_ROM_HI      = 8'hB9;
  localparam logic [7:0] PORT_ROM_SEL     = 8'hBA;
  localparam logic [7:0] PORT_ROM_INC     = 8'hBB;
  localparam logic [7:0] PORT_BOOT_HI     = 8'hF8;
  localparam logic [7:0] PORT_BOOT_DATA   = 8'hF9;
  localparam logic [7:0] PORT_FL_BOOT_LD  = 8'h8A;
  localparam logic [7:0] PORT_FL_BOOT_SV  = 8'h8B;
  localparam logic [7:0] PORT_FL_EXP_LD   = 8'h8C;
  localparam logic [7:0] PORT_FL_EXP_SV   = 8'h8D;
  localparam logic [7:0] PORT_EXP_LO      = 8'hA4;
  localparam logic [7:0] PORT_EXP_MID     = 8'hA5;
  localparam logic [7:0] PORT_EXP_HI      = 8'hA6;
  localparam logic [7:0] PORT_EXP_DATA    = 8'hA7;
  localparam logic [7:0] PORT_FONT_CLR    = 8'h70;
  localparam logic [7:0] PORT_FONT_DATA   = 8'h71;
  localparam logic [7:0] PORT_FONT_SET    = 8'h72;
  localparam logic [7:0] PORT_VIDEO_CTL   = 8'hE8;
  localparam logic [7:0] PORT_PLANE_CTL   = 8'hF4;

  // memory window bounds
  localparam logic [15:0] LOW_TEXT_BASE  = 16'h5000;
  localparam logic [15:0] LOW_GFX_BASE   = 16'h6000;
  localparam logic [15:0] LOW_GFX_END    = 16'h8000;
  localparam logic [15:0] HIGH_TEXT_BASE = 16'hD000;
  localparam logic [15:0] HIGH_GFX_BASE  = 16'hE000;

  localparam logic [1:0] PLANE_SEL_1 = 2'd1;
  localparam logic [1:0] PLANE_SEL_2 = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } req_t;

  typedef struct packed {
    logic              responds;
    logic [3:0]        target;
    logic [ADDR_W-1:0] store_address;
    logic              is_write;
    logic [7:0]        write_data;
    logic              reverse_bits;
    logic [2:0]        flash_request;
    logic [5:0]        flash_page;
    logic              wide_text_mode;
    logic              graphics_shown;
    logic [2:0]        plane_show_mask;
  } rsp_t;

endpackage
`default_nettype wire

/* src/expansion_card_bus_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// expansion_card_bus_decoder: host bus access decoder of an expansion card
// keeps the store pointers and display modes, emits one result, at most one store access, per
// host transfer
// ----------------------------------------------------------------------------
// Each host access (io read, io write or memory write) accepted on req gives
// exactly one result on rsp: the store to touch and the byte address inside
// it, a write strobe with data, a bit-reverse flag for ROM reads, any flash
// page load or save request, and the display modes as they stand after the
// access. The block takes one access every clock while the result is not
// stalled. An accepted access sits in the input register; the single pass of
// pointer update logic behind it loads the result register, which also
// writes the pointers back so the next access sees them, and the result
// transfers from the result register. A stalled result holds the input
// register, and req_ready stays low until the result transfers.
// The expanded memory pointer is folded into range by constant compares before
// use; the font pointer is kept below FONT_BYTES at all times.
module expansion_card_bus_decoder #(
  parameter int EXPANDED_BYTES = ecbd_pkg::EXPANDED_BYTES_DEF,
  parameter int FONT_BYTES     = ecbd_pkg::FONT_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ecbd_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output ecbd_pkg::rsp_t     rsp
);

  localparam int AW = ecbd_pkg::ADDR_W;
  localparam int FW = ecbd_pkg::FONT_PTR_W;
  // largest multiplier of the expanded size that a pointer can reach
  localparam int EXP_MAX_Q = ((2 ** AW) - 1) / EXPANDED_BYTES;

  // input register
  logic           s1_valid;
  ecbd_pkg::req_t s1;
  logic           advance;

  // pointer and mode state
  logic [ecbd_pkg::ROM_PTR_W-1:0]  rom_pointer, rom_pointer_next;
  logic                            rom_select_kanji, rom_select_kanji_next;
  logic [ecbd_pkg::BOOT_PTR_W-1:0] boot_pointer, boot_pointer_next;
  logic [AW-1:0]                   expanded_pointer, expanded_pointer_next;
  logic [FW-1:0]                   font_pointer, font_pointer_next;
  logic                            video_write_enable, video_write_enable_next;
  logic                            window_low_map, window_low_map_next;
  logic                            wide_text, wide_text_next;
  logic                            graphics_on, graphics_on_next;
  logic [1:0]                      write_plane, write_plane_next;
  logic [2:0]                      plane_mask, plane_mask_next;

  ecbd_pkg::rsp_t result;

  logic [7:0]    port;
  logic [AW:0]   exp_sub;
  logic [AW-1:0] exp_take;
  logic [FW:0]   font_inc;
  logic [16:0]   rom_offset;
  logic          text_hit, gfx_hit;

  // the result register frees up when empty or when its transfer completes
  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      s1 <= req;
    end
  end

  assign port = s1.bus_address[7:0];

  // expanded pointer folded into range: subtract the largest multiple reached
  always_comb begin
    exp_sub = '0;
    for (int j = 1; j <= 7; j++) begin
      if (j <= EXP_MAX_Q && {1'b0, expanded_pointer} >= (AW+1)'(j * EXPANDED_BYTES)) begin
        exp_sub = (AW+1)'(j * EXPANDED_BYTES);
      end
    end
    exp_take = AW'({1'b0, expanded_pointer} - exp_sub);
  end

  // font pointer is always below FONT_BYTES, so a wrap is one compare
  assign font_inc   = {1'b0, font_pointer} + (FW+1)'(1);
  assign rom_offset = {rom_pointer, port[0]};

  // memory window decode
  always_comb begin
    if (window_low_map) begin
      text_hit = s1.bus_address >= ecbd_pkg::LOW_TEXT_BASE &&
                 s1.bus_address <  ecbd_pkg::LOW_GFX_BASE;
      gfx_hit  = s1.bus_address >= ecbd_pkg::LOW_GFX_BASE &&
                 s1.bus_address <  ecbd_pkg::LOW_GFX_END;
    end else begin
      text_hit = s1.bus_address >= ecbd_pkg::HIGH_TEXT_BASE &&
                 s1.bus_address <  ecbd_pkg::HIGH_GFX_BASE;
      gfx_hit  = s1.bus_address >= ecbd_pkg::HIGH_GFX_BASE;
    end
  end

  // single pass: result and next state of the access in the input register
  always_comb begin
    rom_pointer_next        = rom_pointer;
    rom_select_kanji_next   = rom_select_kanji;
    boot_pointer_next       = boot_pointer;
    expanded_pointer_next   = expanded_pointer;
    font_pointer_next       = font_pointer;
    video_write_enable_next = video_write_enable;
    window_low_map_next     = window_low_map;
    wide_text_next          = wide_text;
    graphics_on_next        = graphics_on;
    write_plane_next        = write_plane;
    plane_mask_next         = plane_mask;

    result               = '0;
    result.target        = ecbd_pkg::TGT_NONE;
    result.flash_request = ecbd_pkg::FL_NONE;

    unique case (s1.opcode)
      ecbd_pkg::OP_IO_READ: begin
        unique case (port)
          ecbd_pkg::PORT_ROM_LO, ecbd_pkg::PORT_ROM_HI,
          ecbd_pkg::PORT_ROM_SEL, ecbd_pkg::PORT_ROM_INC: begin
            result.responds = 1'b1;
            if (rom_select_kanji) begin
              result.target        = ecbd_pkg::TGT_KANJI;
              result.store_address = AW'(rom_offset);
            end else begin
              result.target        = ecbd_pkg::TGT_DICT;
              result.store_address = AW'(rom_offset[13:0]);
            end
            // upper pair of ports returns the byte bit-reversed
            result.reverse_bits = port[1];
            if (port[0]) begin
              rom_pointer_next = rom_pointer + 16'd1;
            end
          end
          ecbd_pkg::PORT_BOOT_DATA: begin
            result.responds      = 1'b1;
            result.target        = ecbd_pkg::TGT_BOOT;
            result.store_address = AW'(boot_pointer);
          end
          ecbd_pkg::PORT_EXP_DATA: begin
            result.responds       = 1'b1;
            result.target         = ecbd_pkg::TGT_EXPANDED;
            result.store_address  = exp_take;
            expanded_pointer_next = exp_take + AW'(1);
          end
          default: begin
          end
        endcase
      end

      ecbd_pkg::OP_IO_WRITE: begin
        unique case (port)
          ecbd_pkg::PORT_ROM_LO:  rom_pointer_next = {rom_pointer[15:8], s1.bus_data};
          ecbd_pkg::PORT_ROM_HI:  rom_pointer_next = {s1.bus_data, rom_pointer[7:0]};
          ecbd_pkg::PORT_ROM_SEL: rom_select_kanji_next = s1.bus_data[0];
          ecbd_pkg::PORT_ROM_INC: rom_pointer_next = rom_pointer + 16'd1;
          ecbd_pkg::PORT_BOOT_HI: begin
            boot_pointer_next = {s1.bus_data[6:0], boot_pointer[7:0]};
          end
          ecbd_pkg::PORT_BOOT_DATA: begin
            boot_pointer_next = {boot_pointer[14:8], s1.bus_data};
          end
          ecbd_pkg::PORT_FL_BOOT_LD: begin
            result.flash_request = ecbd_pkg::FL_BOOT_LOAD;
            result.flash_page    = s1.bus_data[5:0];
          end
          ecbd_pkg::PORT_FL_BOOT_SV: begin
            result.flash_request = ecbd_pkg::FL_BOOT_SAVE;
            result.flash_page    = s1.bus_data[5:0];
          end
          ecbd_pkg::PORT_FL_EXP_LD: begin
            result.flash_request = ecbd_pkg::FL_EXPANDED_LOAD;
            result.flash_page    = {1'b0, s1.bus_data[4:0]};
          end
          ecbd_pkg::PORT_FL_EXP_SV: begin
            result.flash_request = ecbd_pkg::FL_EXPANDED_SAVE;
            result.flash_page    = {1'b0, s1.bus_data[4:0]};
          end
          ecbd_pkg::PORT_EXP_LO: begin
            expanded_pointer_next = {expanded_pointer[18:8], s1.bus_data};
          end
          ecbd_pkg::PORT_EXP_MID: begin
            expanded_pointer_next = {expanded_pointer[18:16], s1.bus_data,
                                     expanded_pointer[7:0]};
          end
          ecbd_pkg::PORT_EXP_HI: begin
            expanded_pointer_next = {s1.bus_data[2:0], expanded_pointer[15:0]};
          end
          ecbd_pkg::PORT_EXP_DATA: begin
            result.target         = ecbd_pkg::TGT_EXPANDED;
            result.store_address  = exp_take;
            result.is_write       = 1'b1;
            result.write_data     = s1.bus_data;
            expanded_pointer_next = exp_take + AW'(1);
          end
          ecbd_pkg::PORT_FONT_CLR: font_pointer_next = '0;
          ecbd_pkg::PORT_FONT_DATA: begin
            result.target        = ecbd_pkg::TGT_FONT;
            result.store_address = AW'(font_pointer);
            result.is_write      = 1'b1;
            result.write_data    = s1.bus_data;
            if (font_inc == (FW+1)'(FONT_BYTES)) begin
              font_pointer_next = '0;
            end else begin
              font_pointer_next = FW'(font_inc);
            end
          end
          // eight bytes per glyph, always below the smallest font size
          ecbd_pkg::PORT_FONT_SET: font_pointer_next = FW'({s1.bus_data, 3'b000});
          ecbd_pkg::PORT_VIDEO_CTL: begin
            video_write_enable_next = s1.bus_data[7];
            window_low_map_next     = s1.bus_data[6];
            wide_text_next          = s1.bus_data[5];
          end
          ecbd_pkg::PORT_PLANE_CTL: begin
            plane_mask_next  = {1'b0, s1.bus_data[2:1]};
            write_plane_next = {1'b0, s1.bus_data[0]} + 2'd1;
            graphics_on_next = |s1.bus_data[7:1];
          end
          default: begin
          end
        endcase
      end

      ecbd_pkg::OP_MEM_WRITE: begin
        if (video_write_enable) begin
          if (text_hit) begin
            result.target        = ecbd_pkg::TGT_TEXT;
            result.store_address = AW'(s1.bus_address[11:0]);
            result.is_write      = 1'b1;
            result.write_data    = s1.bus_data;
          end else if (gfx_hit) begin
            // other plane selections swallow the write
            if (write_plane == ecbd_pkg::PLANE_SEL_1) begin
              result.target        = ecbd_pkg::TGT_PLANE1;
              result.store_address = AW'(s1.bus_address[12:0]);
              result.is_write      = 1'b1;
              result.write_data    = s1.bus_data;
            end else if (write_plane == ecbd_pkg::PLANE_SEL_2) begin
              result.target        = ecbd_pkg::TGT_PLANE2;
              result.store_address = AW'(s1.bus_address[12:0]);
              result.is_write      = 1'b1;
              result.write_data    = s1.bus_data;
            end
          end
        end
      end

      default: begin
      end
    endcase

    // display modes reflect the state after this access
    result.wide_text_mode  = wide_text_next;
    result.graphics_shown  = graphics_on_next;
    result.plane_show_mask = plane_mask_next;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_pointer        <= '0;
      rom_select_kanji   <= 1'b0;
      boot_pointer       <= '0;
      expanded_pointer   <= '0;
      font_pointer       <= '0;
      video_write_enable <= 1'b0;
      window_low_map     <= 1'b0;
      wide_text          <= 1'b0;
      graphics_on        <= 1'b0;
      write_plane        <= 2'd0;
      plane_mask         <= 3'd7;
      rsp_valid          <= 1'b0;
    end else begin
      if (advance) begin
        rom_pointer        <= rom_pointer_next;
        rom_select_kanji   <= rom_select_kanji_next;
        boot_pointer       <= boot_pointer_next;
        expanded_pointer   <= expanded_pointer_next;
        font_pointer       <= font_pointer_next;
        video_write_enable <= video_write_enable_next;
        window_low_map     <= window_low_map_next;
        wide_text          <= wide_text_next;
        graphics_on        <= graphics_on_next;
        write_plane        <= write_plane_next;
        plane_mask         <= plane_mask_next;
        rsp_valid          <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  // font pointer never leaves the font RAM
  a_font_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, font_pointer} < (FW+1)'(FONT_BYTES))
    else $error("font pointer beyond font RAM");

  // expanded accesses always land inside the expanded memory
  a_exp_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.target == ecbd_pkg::TGT_EXPANDED |->
      {1'b0, rsp.store_address} < (AW+1)'(EXPANDED_BYTES))
    else $error("expanded address out of range");

  // an answered io read never carries a write strobe
  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.responds |-> !rsp.is_write)
    else $error("io read answered with a write strobe");

  // a stalled result register must not be overwritten by the pipeline
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && rsp == $past(rsp))
    else $error("pending result lost");

endmodule
`default_nettype wire
